/* hdl/smv_pkg.sv */
// Package with types, constants and the exponent table for the softmax block.
package smv_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned EXP_W    = 17;
  localparam int unsigned SUM_W    = 24;
  localparam int unsigned PROB_W   = 16;
  localparam int unsigned QUOT_W   = 17;
  localparam logic [9:0]  LOG2E_Q8 = 10'd369;

  typedef enum logic [5:0] {
    ST_LOAD = 6'b000001,
    ST_SUMR = 6'b000010,
    ST_SUMA = 6'b000100,
    ST_EMTR = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  function automatic logic [EXP_W-1:0] exp2_frac(input logic [3:0] idx);
    logic [EXP_W-1:0] v;
    case (idx)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd62757;
      4'd2:    v = 17'd60097;
      4'd3:    v = 17'd57549;
      4'd4:    v = 17'd55109;
      4'd5:    v = 17'd52773;
      4'd6:    v = 17'd50535;
      4'd7:    v = 17'd48393;
      4'd8:    v = 17'd46341;
      4'd9:    v = 17'd44376;
      4'd10:   v = 17'd42495;
      4'd11:   v = 17'd40693;
      4'd12:   v = 17'd38968;
      4'd13:   v = 17'd37316;
      4'd14:   v = 17'd35734;
      4'd15:   v = 17'd34219;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/softmax_vector.sv */
// Softmax over one streamed vector with a shared exponent unit and serial divider.
//
//  channel | dir | handshake          | payload
//  s_axis  | in  | tvalid/tready      | tdata: sample, tlast: last_element
//  m_axis  | out | tvalid/tready      | tdata: probability, tuser: overflow, tlast
//
// Load: one element per cycle. At the flagged element the block walks the store
// twice: per element a memory read and an exp-and-add step for the sum, then per
// element a read, an exp step that starts the divider, the divider steps and an output step.
// Reset clears control state; the store needs none. Output stalls hold the result.
module softmax_vector #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] probability
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // [0] overflow
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  smv_pkg::state_e state_q, state_d;

  logic signed [15:0] mem [MAX_LEN];
  logic signed [15:0] rd_q;
  logic [CW-1:0]      cnt_q, idx_q;
  logic signed [15:0] max_q;
  logic [smv_pkg::SUM_W-1:0] sum_q;
  logic               ovf_q;
  logic [40:0]        rem_q;
  logic [smv_pkg::QUOT_W-1:0] quo_q;
  logic [4:0]         bit_q;
  logic [15:0]        prob_q;
  logic               last_q;

  logic               acc_in, store_ok;
  logic [AW-1:0]      rd_addr;
  logic [15:0]        gap;
  logic [25:0]        scaled;
  logic [17:0]        y;
  logic [smv_pkg::EXP_W-1:0] exp_c;

  assign s_axis_tready = (state_q == smv_pkg::ST_LOAD);
  assign acc_in        = s_axis_tvalid && s_axis_tready;
  assign store_ok      = (cnt_q < CW'(MAX_LEN));
  assign rd_addr       = idx_q[AW-1:0];

  assign gap    = 16'(max_q - rd_q);
  assign scaled = {10'd0, gap} * {16'd0, smv_pkg::LOG2E_Q8};
  assign y      = scaled[25:8];
  always_comb begin
    if (y[17:8] >= 10'd17) begin
      exp_c = '0;
    end else begin
      exp_c = smv_pkg::exp2_frac(y[7:4]) >> y[12:8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in && store_ok) begin
      mem[cnt_q[AW-1:0]] <= s_axis_tdata;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      smv_pkg::ST_LOAD: begin
        if (acc_in && s_axis_tlast) begin
          state_d = smv_pkg::ST_SUMR;
        end
      end
      smv_pkg::ST_SUMR: state_d = smv_pkg::ST_SUMA;
      smv_pkg::ST_SUMA: begin
        state_d = (idx_q + CW'(1) == cnt_q) ? smv_pkg::ST_EMTR : smv_pkg::ST_SUMR;
      end
      smv_pkg::ST_EMTR: state_d = smv_pkg::ST_DIV;
      smv_pkg::ST_DIV: begin
        if (bit_q == 5'd17) begin
          state_d = smv_pkg::ST_OUT;
        end
      end
      smv_pkg::ST_OUT: begin
        if (m_axis_tready) begin
          state_d = last_q ? smv_pkg::ST_LOAD : smv_pkg::ST_EMTR;
        end
      end
      default: state_d = smv_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smv_pkg::ST_LOAD;
      cnt_q   <= '0;
      idx_q   <= '0;
      max_q   <= 16'sh8000;
      sum_q   <= '0;
      ovf_q   <= 1'b0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        smv_pkg::ST_LOAD: begin
          if (acc_in) begin
            if (store_ok) begin
              cnt_q <= cnt_q + CW'(1);
              if ($signed(s_axis_tdata) > max_q) begin
                max_q <= s_axis_tdata;
              end
            end else begin
              ovf_q <= 1'b1;
            end
            idx_q <= '0;
            sum_q <= '0;
          end
        end
        smv_pkg::ST_SUMA: begin
          sum_q <= sum_q + smv_pkg::SUM_W'(exp_c);
          idx_q <= (idx_q + CW'(1) == cnt_q) ? '0 : idx_q + CW'(1);
        end
        smv_pkg::ST_EMTR: begin
          bit_q <= '0;
        end
        smv_pkg::ST_DIV: begin
          bit_q <= bit_q + 5'd1;
        end
        smv_pkg::ST_OUT: begin
          if (m_axis_tready) begin
            if (last_q) begin
              cnt_q <= '0;
              idx_q <= '0;
              max_q <= 16'sh8000;
              sum_q <= '0;
              ovf_q <= 1'b0;
            end else begin
              idx_q <= idx_q + CW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // restoring division of (e*65536 + sum/2) by sum, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (state_q == smv_pkg::ST_EMTR) begin
      last_q <= (idx_q + CW'(1) == cnt_q);
    end
    if (state_q == smv_pkg::ST_DIV && bit_q == 5'd0) begin
      rem_q <= 41'({exp_c, 16'd0} + 33'(sum_q >> 1));
      quo_q <= '0;
    end else if (state_q == smv_pkg::ST_DIV) begin
      if (rem_q >= {17'd0, sum_q} << (5'd17 - bit_q)) begin
        rem_q <= rem_q - ({17'd0, sum_q} << (5'd17 - bit_q));
        quo_q <= {quo_q[smv_pkg::QUOT_W-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[smv_pkg::QUOT_W-2:0], 1'b0};
      end
    end
    if (state_q == smv_pkg::ST_DIV && bit_q == 5'd17) begin
      prob_q <= quo_q[15] ? 16'hFFFF : {quo_q[14:0], (rem_q >= {17'd0, sum_q})};
    end
  end

  assign m_axis_tvalid = (state_q == smv_pkg::ST_OUT);
  assign m_axis_tdata  = prob_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = ovf_q;

endmodule
